// ----- rtl/pct_pkg.sv -----
// Shared types, request codes and the gamma ramp table for the palette color path.
`timescale 1ns / 1ps
`default_nettype none
package pct_pkg;

  localparam int XLAT_WORDS  = 24576;
  localparam int CURVE_AW    = 13;
  localparam int CURVE_WORDS = 2 ** CURVE_AW;

  localparam logic [7:0]  FLAT_SHADE = 8'h40;
  localparam logic [12:0] POLY_BASE  = 13'h1000;
  localparam logic [7:0]  ALPHA_BITS = 8'hff;

  localparam logic [1:0] BLK_RED   = 2'd0;
  localparam logic [1:0] BLK_GREEN = 2'd1;
  localparam logic [1:0] BLK_BLUE  = 2'd2;

  localparam logic [2:0] FUNC_WR_PAL  = 3'd0;
  localparam logic [2:0] FUNC_WR_XLAT = 3'd1;
  localparam logic [2:0] FUNC_PEN     = 3'd2;
  localparam logic [2:0] FUNC_POLY    = 3'd3;
  localparam logic [2:0] FUNC_TONE    = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [14:0] ram_address;
    logic [15:0] write_data;
    logic [11:0] pen_index;
    logic [9:0]  poly_offset;
    logic [4:0]  component;
    logic [7:0]  shade;
  } req_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic [4:0]  comp_red;
    logic [4:0]  comp_green;
    logic [4:0]  comp_blue;
  } rsp_t;

  typedef logic [255:0][7:0] gamma_lut_t;

  function automatic gamma_lut_t build_gamma();
    gamma_lut_t lut;
    int         v;
    for (int i = 0; i < 256; i++) begin
      v = (i <= 64) ? 0 : ((i - 64) * 255) / 191;
      lut[i] = v[7:0];
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma();

endpackage
`default_nettype wire

// ----- rtl/pct_curve_ram.sv -----
// One 8192 x 8 tone curve block with a write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pct_curve_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [pct_pkg::CURVE_AW-1:0]  wr_addr,
  input  logic [7:0]                    wr_data,
  input  logic [pct_pkg::CURVE_AW-1:0]  rd_addr,
  output logic [7:0]                    rd_data
);
  import pct_pkg::*;

  logic [7:0] mem [CURVE_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/palette_colour_translation_top.sv -----
// Top level of the palette color path: palette read, curve read and gamma/pack stages.
//
// One request is taken every clock; busy is high only while rst is high. Palette and
// translation writes give no result. Pen, polygon and tone requests give exactly one
// result, with done high for one cycle. The result passes through the palette memory read,
// the three curve memory reads (one memory per color block, read in parallel) and the
// gamma and pack stage. Writes land in request order, so a request sees every write
// taken before it. Results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module palette_colour_translation_top #(
  parameter int PALETTE_WORDS = 8192,
  parameter int PEN_COUNT     = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pct_pkg::req_t req,
  output logic          done,
  output pct_pkg::rsp_t rsp
);
  import pct_pkg::*;

  localparam int PAL_AW = $clog2(PALETTE_WORDS);

  logic [14:0] pal_mem [PALETTE_WORDS];

  logic              accept;
  logic [12:0]       poly_entry;
  logic              pen_ok;
  logic              poly_ok;
  logic              pal_wr;
  logic [PAL_AW-1:0] pal_rd_addr;

  logic        s1_valid;
  req_t        s1_req;
  logic        s1_in_range;
  logic [14:0] pal_rdata;

  logic                s1_has_rsp;
  logic                s1_is_pen;
  logic [4:0]          comp_r;
  logic [4:0]          comp_g;
  logic [4:0]          comp_b;
  logic [7:0]          rd_shade;
  logic                xlat_wr;
  logic [1:0]          xlat_blk;
  logic [CURVE_AW-1:0] xlat_wr_addr;

  logic        s2_valid;
  logic [2:0]  s2_func;
  logic        s2_in_range;
  logic [14:0] s2_pal;
  logic [7:0]  curve_r;
  logic [7:0]  curve_g;
  logic [7:0]  curve_b;

  rsp_t rsp_next;

  assign busy   = rst;
  assign accept = start && !busy;

  assign poly_entry  = POLY_BASE + 13'(req.poly_offset);
  assign pen_ok      = (32'(req.pen_index) < PEN_COUNT) && (32'(req.pen_index) < PALETTE_WORDS);
  assign poly_ok     = 32'(poly_entry) < PALETTE_WORDS;
  assign pal_wr      = accept && (req.func == FUNC_WR_PAL) && (32'(req.ram_address) < PALETTE_WORDS);
  assign pal_rd_addr = (req.func == FUNC_POLY) ? PAL_AW'(poly_entry) : PAL_AW'(req.pen_index);

  always_ff @(posedge clk) begin
    if (pal_wr) begin
      pal_mem[PAL_AW'(req.ram_address)] <= req.write_data[14:0];
    end
    pal_rdata <= pal_mem[pal_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_req      <= req;
    s1_in_range <= (req.func == FUNC_POLY) ? poly_ok : pen_ok;
  end

  assign s1_has_rsp = (s1_req.func == FUNC_PEN) || (s1_req.func == FUNC_POLY) ||
                      (s1_req.func == FUNC_TONE);
  assign s1_is_pen  = s1_req.func == FUNC_PEN;
  assign comp_r     = s1_is_pen ? pal_rdata[4:0]   : s1_req.component;
  assign comp_g     = s1_is_pen ? pal_rdata[9:5]   : s1_req.component;
  assign comp_b     = s1_is_pen ? pal_rdata[14:10] : s1_req.component;
  assign rd_shade   = s1_is_pen ? FLAT_SHADE : s1_req.shade;

  assign xlat_wr      = s1_valid && (s1_req.func == FUNC_WR_XLAT) &&
                        (32'(s1_req.ram_address) < XLAT_WORDS);
  assign xlat_blk     = s1_req.ram_address[14:13];
  assign xlat_wr_addr = s1_req.ram_address[CURVE_AW-1:0];

  pct_curve_ram u_ram_red (
    .clk     (clk),
    .wr_en   (xlat_wr && (xlat_blk == BLK_RED)),
    .wr_addr (xlat_wr_addr),
    .wr_data (s1_req.write_data[7:0]),
    .rd_addr ({comp_r, rd_shade}),
    .rd_data (curve_r)
  );

  pct_curve_ram u_ram_green (
    .clk     (clk),
    .wr_en   (xlat_wr && (xlat_blk == BLK_GREEN)),
    .wr_addr (xlat_wr_addr),
    .wr_data (s1_req.write_data[7:0]),
    .rd_addr ({comp_g, rd_shade}),
    .rd_data (curve_g)
  );

  pct_curve_ram u_ram_blue (
    .clk     (clk),
    .wr_en   (xlat_wr && (xlat_blk == BLK_BLUE)),
    .wr_addr (xlat_wr_addr),
    .wr_data (s1_req.write_data[7:0]),
    .rd_addr ({comp_b, rd_shade}),
    .rd_data (curve_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_has_rsp;
    end
    s2_func     <= s1_req.func;
    s2_in_range <= s1_in_range;
    s2_pal      <= pal_rdata;
  end

  always_comb begin
    rsp_next = '0;
    case (s2_func)
      FUNC_PEN: begin
        if (s2_in_range) begin
          rsp_next.pixel_word = {ALPHA_BITS, GAMMA_LUT[curve_b], GAMMA_LUT[curve_g],
                                 GAMMA_LUT[curve_r]};
        end else begin
          rsp_next.pixel_word = {ALPHA_BITS, 24'h0};
        end
      end
      FUNC_TONE: begin
        rsp_next.pixel_word = {ALPHA_BITS, GAMMA_LUT[curve_b], GAMMA_LUT[curve_g],
                               GAMMA_LUT[curve_r]};
      end
      FUNC_POLY: begin
        if (s2_in_range) begin
          rsp_next.comp_red   = s2_pal[4:0];
          rsp_next.comp_green = s2_pal[9:5];
          rsp_next.comp_blue  = s2_pal[14:10];
        end
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    rsp <= rsp_next;
  end

endmodule
`default_nettype wire

// ----- rtl/pct_checker.sv -----
// Port-level checks on the palette colour path and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module pct_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input pct_pkg::req_t req,
  input logic          done,
  input pct_pkg::rsp_t rsp
);
  import pct_pkg::*;

  a_no_stall: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy high outside reset");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3) &&
             ($past(req.func, 3) == FUNC_PEN || $past(req.func, 3) == FUNC_POLY ||
              $past(req.func, 3) == FUNC_TONE))
    else $error("result without a matching request");

  a_lookup_answers: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req.func == FUNC_PEN || req.func == FUNC_POLY ||
                       req.func == FUNC_TONE) |-> ##3 done)
    else $error("lookup request lost");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req.func == FUNC_WR_PAL || req.func == FUNC_WR_XLAT) |-> ##3 !done)
    else $error("write request produced a result");

  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.pixel_word[31:24] == ALPHA_BITS && rsp.comp_red == 5'd0 &&
              rsp.comp_green == 5'd0 && rsp.comp_blue == 5'd0) ||
             (rsp.pixel_word == 32'd0))
    else $error("result mixes colour and components");

endmodule

bind palette_colour_translation_top pct_checker u_pct_checker (.*);
`default_nettype wire

// ----- test/tb_palette_colour_translation_top.sv -----
// Self-checking testbench for the palette color path: random and directed requests, predicted colors.
`timescale 1ns / 1ps
`default_nettype none
module tb_palette_colour_translation_top;
  import pct_pkg::*;

  localparam int PAL_WORDS      = 8192;
  localparam int PEN_COUNT      = 4096;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 140;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  req_t  req = '0;
  logic  done;
  rsp_t  rsp;

  palette_colour_translation_top #(
    .PALETTE_WORDS(PAL_WORDS),
    .PEN_COUNT(PEN_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // predicted contents of the two stores
  logic [14:0] palette_mem [PAL_WORDS];
  logic [7:0]  curve_mem   [XLAT_WORDS];
  rsp_t        colour_due  [$];

  // generator bookkeeping: which entries hold known data
  bit          palette_set    [PAL_WORDS];
  logic [14:0] palette_shadow [PAL_WORDS];
  bit          curve_set      [XLAT_WORDS];
  req_t        request_backlog [$];

  int   idle_pct = 0;
  int   queued_total = 0;
  int   accepted_total = 0;
  int   mismatches = 0;
  int   results_checked = 0;
  int   n_writes = 0, n_pens = 0, n_polys = 0, n_tones = 0, n_unknown = 0;
  int   idle_cycles = 0;
  logic took = 1'b0;

  function automatic int curve_addr(logic [1:0] blk, logic [4:0] comp, logic [7:0] shade);
    return int'(blk) * CURVE_WORDS + int'(comp) * 256 + int'(shade);
  endfunction

  function automatic logic [7:0] gamma_level(logic [7:0] level);
    int scaled;
    scaled = 0;
    if (level > 8'd64) scaled = ((int'(level) - 64) * 255) / 191;
    return 8'(scaled);
  endfunction

  function automatic logic [7:0] curve_colour(logic [1:0] blk, logic [4:0] comp,
                                              logic [7:0] shade);
    return gamma_level(curve_mem[curve_addr(blk, comp, shade)]);
  endfunction

  function automatic req_t noise_fields();
    logic [95:0] bits;
    bits = {$urandom(), $urandom(), $urandom()};
    return bits[$bits(req_t)-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic apply_request(req_t r);
    rsp_t        want;
    logic [14:0] word;
    want = '0;
    case (r.func)
      FUNC_WR_PAL: begin
        n_writes++;
        if (r.ram_address < PAL_WORDS) palette_mem[r.ram_address] = r.write_data[14:0];
      end
      FUNC_WR_XLAT: begin
        n_writes++;
        if (r.ram_address < XLAT_WORDS) curve_mem[r.ram_address] = r.write_data[7:0];
      end
      FUNC_PEN: begin
        n_pens++;
        if (r.pen_index < PEN_COUNT && r.pen_index < PAL_WORDS) begin
          word = palette_mem[r.pen_index];
          want.pixel_word = {ALPHA_BITS,
                             curve_colour(BLK_BLUE, word[14:10], FLAT_SHADE),
                             curve_colour(BLK_GREEN, word[9:5], FLAT_SHADE),
                             curve_colour(BLK_RED, word[4:0], FLAT_SHADE)};
        end else begin
          want.pixel_word = {ALPHA_BITS, 24'h0};
        end
        colour_due.push_back(want);
      end
      FUNC_POLY: begin
        n_polys++;
        if (int'(POLY_BASE) + int'(r.poly_offset) < PAL_WORDS) begin
          word = palette_mem[int'(POLY_BASE) + int'(r.poly_offset)];
          want.comp_red   = word[4:0];
          want.comp_green = word[9:5];
          want.comp_blue  = word[14:10];
        end
        colour_due.push_back(want);
      end
      FUNC_TONE: begin
        n_tones++;
        want.pixel_word = {ALPHA_BITS,
                           curve_colour(BLK_BLUE, r.component, r.shade),
                           curve_colour(BLK_GREEN, r.component, r.shade),
                           curve_colour(BLK_RED, r.component, r.shade)};
        colour_due.push_back(want);
      end
      default: n_unknown++;
    endcase
  endtask

  task automatic check_colour(rsp_t got);
    rsp_t want;
    if (colour_due.size() == 0) begin
      report_mismatch("result with no request due", got.pixel_word, 32'h0);
    end else begin
      want = colour_due.pop_front();
      results_checked++;
      if (got.pixel_word !== want.pixel_word)
        report_mismatch("pixel_word", got.pixel_word, want.pixel_word);
      if (got.comp_red !== want.comp_red)
        report_mismatch("comp_red", 32'(got.comp_red), 32'(want.comp_red));
      if (got.comp_green !== want.comp_green)
        report_mismatch("comp_green", 32'(got.comp_green), 32'(want.comp_green));
      if (got.comp_blue !== want.comp_blue)
        report_mismatch("comp_blue", 32'(got.comp_blue), 32'(want.comp_blue));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      took <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (done) check_colour(rsp);
      if (start && !busy) begin
        apply_request(req);
        accepted_total++;
        took <= 1'b1;
      end else begin
        took <= 1'b0;
      end
      if ((start && !busy) || done || (accepted_total == queued_total && colour_due.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d requests pending", queued_total - accepted_total);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (request_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        req   <= request_backlog.pop_front();
        start <= 1'b1;
      end else begin
        req   <= noise_fields();
        start <= 1'b0;
      end
    end
  end

  task automatic queue_item(req_t r);
    if (r.func == FUNC_WR_PAL && r.ram_address < PAL_WORDS) begin
      palette_set[r.ram_address]    = 1'b1;
      palette_shadow[r.ram_address] = r.write_data[14:0];
    end
    if (r.func == FUNC_WR_XLAT && r.ram_address < XLAT_WORDS)
      curve_set[r.ram_address] = 1'b1;
    request_backlog.push_back(r);
    queued_total++;
  endtask

  task automatic send_write(logic [2:0] func, logic [14:0] addr, logic [15:0] data);
    req_t r;
    r = noise_fields();
    r.func        = func;
    r.ram_address = addr;
    r.write_data  = data;
    queue_item(r);
  endtask

  task automatic fill_palette(int addr);
    if (!palette_set[addr]) send_write(FUNC_WR_PAL, 15'(addr), 16'($urandom()));
  endtask

  task automatic fill_curve(int addr);
    if (!curve_set[addr]) send_write(FUNC_WR_XLAT, 15'(addr), 16'($urandom()));
  endtask

  task automatic send_pen(logic [11:0] pen);
    req_t        r;
    logic [14:0] word;
    fill_palette(int'(pen));
    word = palette_shadow[pen];
    fill_curve(curve_addr(BLK_RED, word[4:0], FLAT_SHADE));
    fill_curve(curve_addr(BLK_GREEN, word[9:5], FLAT_SHADE));
    fill_curve(curve_addr(BLK_BLUE, word[14:10], FLAT_SHADE));
    r = noise_fields();
    r.func      = FUNC_PEN;
    r.pen_index = pen;
    queue_item(r);
  endtask

  task automatic send_poly(logic [9:0] base);
    req_t r;
    fill_palette(int'(POLY_BASE) + int'(base));
    r = noise_fields();
    r.func        = FUNC_POLY;
    r.poly_offset = base;
    queue_item(r);
  endtask

  task automatic send_tone(logic [4:0] comp, logic [7:0] shade);
    req_t r;
    fill_curve(curve_addr(BLK_RED, comp, shade));
    fill_curve(curve_addr(BLK_GREEN, comp, shade));
    fill_curve(curve_addr(BLK_BLUE, comp, shade));
    r = noise_fields();
    r.func      = FUNC_TONE;
    r.component = comp;
    r.shade     = shade;
    queue_item(r);
  endtask

  task automatic send_unknown(logic [2:0] func);
    req_t r;
    r = noise_fields();
    r.func = func;
    queue_item(r);
  endtask

  task automatic random_item();
    int          pick;
    int          spot;
    logic [14:0] addr;
    pick = $urandom_range(0, 99);
    spot = $urandom_range(0, 99);
    if (pick < 20) begin
      if (spot < 30)      addr = 15'($urandom_range(0, 63));
      else if (spot < 70) addr = 15'($urandom_range(0, 5119));
      else if (spot < 88) addr = 15'($urandom_range(5120, PAL_WORDS - 1));
      else                addr = 15'($urandom_range(PAL_WORDS, 32767));
      send_write(FUNC_WR_PAL, addr, 16'($urandom()));
    end else if (pick < 40) begin
      if (spot < 40)
        addr = 15'(curve_addr(2'($urandom_range(0, 2)), 5'($urandom()), FLAT_SHADE));
      else if (spot < 85) addr = 15'($urandom_range(0, XLAT_WORDS - 1));
      else                addr = 15'($urandom_range(XLAT_WORDS, 32767));
      send_write(FUNC_WR_XLAT, addr, 16'($urandom()));
    end else if (pick < 62) begin
      send_pen(spot < 50 ? 12'($urandom_range(0, 63)) : 12'($urandom()));
    end else if (pick < 77) begin
      send_poly(spot < 40 ? 10'($urandom_range(0, 31)) : 10'($urandom()));
    end else if (pick < 95) begin
      send_tone(5'($urandom()), spot < 40 ? FLAT_SHADE : 8'($urandom()));
    end else begin
      send_unknown(3'($urandom_range(5, 7)));
    end
  endtask

  task automatic drain();
    while (accepted_total != queued_total || colour_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    int phase_pct [4];
    phase_pct = '{0, 82, 31, 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_write(FUNC_WR_PAL, 15'd0, 16'hffff);
    send_write(FUNC_WR_PAL, 15'(PAL_WORDS - 1), 16'h0000);
    send_write(FUNC_WR_PAL, 15'(PAL_WORDS), 16'h1234);
    send_write(FUNC_WR_PAL, 15'h7fff, 16'hffff);
    send_write(FUNC_WR_XLAT, 15'(curve_addr(BLK_RED, 5'd31, FLAT_SHADE)), 16'hffff);
    send_write(FUNC_WR_XLAT, 15'(curve_addr(BLK_GREEN, 5'd31, FLAT_SHADE)), 16'h0041);
    send_write(FUNC_WR_XLAT, 15'(curve_addr(BLK_BLUE, 5'd31, FLAT_SHADE)), 16'hab40);
    send_write(FUNC_WR_XLAT, 15'(XLAT_WORDS - 1), 16'h00c0);
    send_write(FUNC_WR_XLAT, 15'(XLAT_WORDS), 16'h0055);
    send_write(FUNC_WR_XLAT, 15'h7fff, 16'hffff);
    send_write(FUNC_WR_XLAT, 15'(curve_addr(BLK_RED, 5'd0, 8'd0)), 16'h0000);
    send_write(FUNC_WR_PAL, 15'(POLY_BASE), 16'hffff);
    send_pen(12'd0);
    send_pen(12'hfff);
    send_poly(10'd0);
    send_poly(10'h3ff);
    send_tone(5'd0, 8'd0);
    send_tone(5'd31, 8'hff);
    send_tone(5'd31, FLAT_SHADE);
    send_unknown(3'd5);
    send_unknown(3'd6);
    send_unknown(3'd7);
    drain();

    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      repeat (PHASE_ITEMS) random_item();
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d writes, %0d pen, %0d polygon, %0d tone and %0d unknown requests",
             n_writes, n_pens, n_polys, n_tones, n_unknown);
    $display("%0d results checked over four sender idle settings", results_checked);
    if (mismatches == 0 && colour_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
